// ===== rtl/htl_pkg.sv =====
// ----------------------------------------------------------------------------
// htl_pkg: shared definitions for the heater thermostat lockout
// Widths, configuration reset values, action codes and register indexes.
// ----------------------------------------------------------------------------
package htl_pkg;

    localparam int TIME_WIDTH_DEF = 16;
    localparam int TEMP_WIDTH_DEF = 16;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int TARGET_W    = 7;
    localparam int HYST_W      = 12;
    localparam int HOLD_W      = 16;
    localparam int COOL_W      = 16;

    localparam logic [TARGET_W-1:0] TARGET_MAX   = 7'd100;
    localparam logic [TARGET_W-1:0] TARGET_RESET = 7'd0;
    localparam logic [HYST_W-1:0]   HYST_RESET   = 12'd32;
    localparam logic [HOLD_W-1:0]   HOLD_RESET   = 16'd30;
    localparam logic [COOL_W-1:0]   COOL_RESET   = 16'd60;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_SAMPLE  = 2'd1;
    localparam logic [1:0] ACT_ENABLE  = 2'd2;
    localparam logic [1:0] ACT_DISABLE = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HYST   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COOL   = 2'd3;

endpackage

// ===== rtl/heater_thermostat_lockout.sv =====
// ----------------------------------------------------------------------------
// heater_thermostat_lockout: on/off heater thermostat with hysteresis
// Each request is a one-second tick, a temperature sample, an enable or a
// disable; each request yields one result with the heater drive and mode.
//
// Usage:
//   Input channel in_valid/in_ready carries action and temperature; output
//   channel out_valid/out_ready carries heat_drive, mode and mode_changed.
//   A request is registered in the input stage at the accepting edge, then
//   evaluated against the thermostat state and written to the result register
//   once that register is free. One request per cycle is sustained while the
//   receiver takes every result; the single state update in the evaluation
//   stage sets that figure.
//   When the receiver stalls, the result register holds and the input stage
//   fills; in_ready drops only when both stages hold a request.
//   Reset puts the block in disabled mode with the heater off and loads the
//   configuration defaults (target 0, hysteresis 32, hold 30, cooldown 60).
//   The configuration port writes a register, with no read-back.
// ----------------------------------------------------------------------------
module heater_thermostat_lockout
    import htl_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF,
    parameter int TEMP_WIDTH = TEMP_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_write,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   action,
    input  logic signed [TEMP_WIDTH-1:0] temperature,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         heat_drive,
    output logic [1:0]                   mode,
    output logic                         mode_changed
);

    typedef enum logic [1:0] {
        MODE_DISABLED = 2'd0,
        MODE_IDLE     = 2'd1,
        MODE_HEATING  = 2'd2,
        MODE_COOLDOWN = 2'd3
    } mode_t;

    localparam int CMP_W = (TIME_WIDTH > HOLD_W) ? TIME_WIDTH : HOLD_W;
    localparam int RND_W = TEMP_WIDTH - 3;
    localparam int DIF_W = TEMP_WIDTH + 2;

    // Configuration registers
    logic [TARGET_W-1:0] target_reg;
    logic [HYST_W-1:0]   hyst_reg;
    logic [HOLD_W-1:0]   hold_reg;
    logic [COOL_W-1:0]   cool_reg;

    // Input stage
    logic                         s1_valid_reg;
    logic [1:0]                   s1_action_reg;
    logic signed [TEMP_WIDTH-1:0] s1_temp_reg;

    // Thermostat state
    mode_t                  mode_reg, mode_next;
    logic                   heater_reg, heater_next;
    logic [TIME_WIDTH-1:0]  since_reg, since_next;
    logic                   first_reg, first_next;
    logic [TIME_WIDTH-1:0]  cool_elapsed_reg, cool_elapsed_next;

    // Result register
    logic       out_valid_reg;
    logic       out_heater_reg;
    logic [1:0] out_mode_reg;
    logic       out_changed_reg;

    logic s1_advance;
    logic in_fire;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_fire    = in_valid && in_ready;

    // ---------------------------------------------------------------- sample
    logic                  t_neg;
    logic [TEMP_WIDTH-1:0] t_mag;
    logic [TEMP_WIDTH:0]   t_sum;
    logic [RND_W-1:0]      t_deg;
    logic                  wanted;
    logic signed [DIF_W-1:0] tgt_ext, t_ext, diff;
    logic [DIF_W-1:0]      abs_diff;
    logic                  time_ok, hyst_ok;
    logic [TIME_WIDTH-1:0] since_inc, cool_inc;
    logic                  enabled;

    always_comb
    begin
        t_neg = s1_temp_reg[TEMP_WIDTH-1];
        t_mag = t_neg ? (TEMP_WIDTH'(0) - TEMP_WIDTH'(s1_temp_reg))
                      : TEMP_WIDTH'(s1_temp_reg);
        t_sum = {1'b0, t_mag} + (TEMP_WIDTH+1)'(8);
        t_deg = t_sum[TEMP_WIDTH:4];
        // A negative rounded value is below any target unless both are zero.
        if (t_neg)
            wanted = (t_deg != '0) || (target_reg != '0);
        else
            wanted = t_deg < RND_W'(target_reg);

        tgt_ext  = $signed(DIF_W'({target_reg, 4'b0000}));
        t_ext    = DIF_W'(s1_temp_reg);
        diff     = tgt_ext - t_ext;
        abs_diff = diff[DIF_W-1] ? (DIF_W'(0) - DIF_W'(diff)) : DIF_W'(diff);
        hyst_ok  = abs_diff > DIF_W'(hyst_reg);
        time_ok  = CMP_W'(since_reg) > CMP_W'(hold_reg);

        since_inc = (since_reg == '1) ? since_reg : since_reg + 1'b1;
        cool_inc  = (cool_elapsed_reg == '1) ? cool_elapsed_reg
                                             : cool_elapsed_reg + 1'b1;
        enabled   = (mode_reg == MODE_IDLE) || (mode_reg == MODE_HEATING);
    end

    // ------------------------------------------------------------ next state
    always_comb
    begin
        mode_next         = mode_reg;
        heater_next       = heater_reg;
        since_next        = since_reg;
        first_next        = first_reg;
        cool_elapsed_next = cool_elapsed_reg;
        case (s1_action_reg)
            ACT_TICK:
            begin
                since_next = since_inc;
                if (mode_reg == MODE_COOLDOWN)
                begin
                    cool_elapsed_next = cool_inc;
                    if (CMP_W'(cool_inc) >= CMP_W'(cool_reg))
                        mode_next = MODE_DISABLED;
                end
            end
            ACT_SAMPLE:
            begin
                if (enabled && (wanted != heater_reg) && time_ok
                    && (hyst_ok || first_reg))
                begin
                    heater_next = wanted;
                    since_next  = '0;
                    first_next  = 1'b0;
                    mode_next   = wanted ? MODE_HEATING : MODE_IDLE;
                end
            end
            ACT_ENABLE:
            begin
                if (!enabled)
                begin
                    since_next = '1;
                    first_next = 1'b1;
                    mode_next  = MODE_IDLE;
                end
            end
            ACT_DISABLE:
            begin
                if (enabled)
                begin
                    heater_next       = 1'b0;
                    cool_elapsed_next = '0;
                    mode_next         = MODE_COOLDOWN;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    // ---------------------------------------------------------- config regs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            hyst_reg   <= HYST_RESET;
            hold_reg   <= HOLD_RESET;
            cool_reg   <= COOL_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TARGET:
                    target_reg <= (cfg_data[TARGET_W-1:0] > TARGET_MAX)
                                  ? TARGET_MAX : cfg_data[TARGET_W-1:0];
                REG_HYST: hyst_reg <= cfg_data[HYST_W-1:0];
                REG_HOLD: hold_reg <= cfg_data[HOLD_W-1:0];
                REG_COOL: cool_reg <= cfg_data[COOL_W-1:0];
                default:  hyst_reg <= hyst_reg;
            endcase
        end
    end

    // ----------------------------------------------------- pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            mode_reg         <= MODE_DISABLED;
            heater_reg       <= 1'b0;
            since_reg        <= '1;
            first_reg        <= 1'b1;
            cool_elapsed_reg <= '0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_advance)
            begin
                out_valid_reg    <= 1'b1;
                mode_reg         <= mode_next;
                heater_reg       <= heater_next;
                since_reg        <= since_next;
                first_reg        <= first_next;
                cool_elapsed_reg <= cool_elapsed_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_action_reg <= action;
            s1_temp_reg   <= temperature;
        end
        if (s1_advance)
        begin
            out_heater_reg  <= heater_next;
            out_mode_reg    <= mode_next;
            out_changed_reg <= (mode_next != mode_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign heat_drive   = out_heater_reg;
    assign mode         = out_mode_reg;
    assign mode_changed = out_changed_reg;

    // ------------------------------------------------------------ assertions
    a_heater_only_heating: assert property (@(posedge clk) disable iff (!rst_n)
        heater_reg |-> (mode_reg == MODE_HEATING))
        else $error("heater on outside heating mode");

    a_result_heater_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && heat_drive) |-> (mode == MODE_HEATING))
        else $error("result shows heater on outside heating mode");

    a_enable_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && (s1_action_reg == ACT_ENABLE) && !enabled)
        |=> ((since_reg == '1) && first_reg && (mode_reg == MODE_IDLE)))
        else $error("enable did not rearm the switch timer");

    a_state_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_advance) |=> $stable(mode_reg) && $stable(since_reg))
        else $error("thermostat state changed without a request");

endmodule

// ===== dv/heater_thermostat_lockout_tb.sv =====
// ----------------------------------------------------------------------------
// heater_thermostat_lockout_tb: self-checking bench for the heater thermostat
// A table of directed requests covers the field extremes, every action and
// the lockout corner cases. Random phases follow, each with new register
// settings. A local thermostat model predicts results the table does not give,
// and results are compared in order while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module heater_thermostat_lockout_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import htl_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_REQUESTS  = 53;

    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_IDLE = 2'd1,
        MODE_HEAT = 2'd2,
        MODE_COOL = 2'd3
    } heat_mode_t;

    typedef struct packed {
        logic       heat;
        heat_mode_t op_mode;
        logic       changed;
    } thermo_result_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_TYPED,
        ROW_CFG
    } row_kind_t;

    // For ROW_CFG, sel is the register index and value the write data.
    typedef struct packed {
        row_kind_t      kind;
        logic [1:0]     sel;
        logic [15:0]    value;
        thermo_result_t want;
    } plan_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [CFG_INDEX_W-1:0]           cfg_index;
    logic [CFG_DATA_W-1:0]            cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic [1:0]                       action;
    logic signed [TEMP_WIDTH_DEF-1:0] temperature;
    logic                             out_valid;
    logic                             out_ready;
    logic                             heat_drive;
    logic [1:0]                       mode;
    logic                             mode_changed;

    // Thermostat model state and its copy of the registers.
    heat_mode_t     cur_mode;
    logic           heater;
    logic [15:0]    since_sw;
    logic           first_pending;
    logic [15:0]    cool_count;
    logic [6:0]     tgt;
    logic [11:0]    hyst;
    logic [15:0]    hold;
    logic [15:0]    cool_len;

    thermo_result_t pending_results[$];
    plan_row_t      plan[$];

    int  error_count;
    int  sent_count;
    int  checked_count;
    int  switch_count;
    int  change_count;
    bit  hold_off_go;
    logic last_heat;

    heater_thermostat_lockout DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .temperature  (temperature),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .heat_drive   (heat_drive),
        .mode         (mode),
        .mode_changed (mode_changed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic thermo_result_t thermostat_next(input logic [1:0] act,
                                                       input logic signed [15:0] temp);
        heat_mode_t     prior;
        bit             active;
        int             t;
        int             mag;
        int             deg;
        int             gap;
        logic           want_heat;
        thermo_result_t r;

        prior  = cur_mode;
        active = (cur_mode == MODE_IDLE) || (cur_mode == MODE_HEAT);
        case (act)
            ACT_TICK:
            begin
                if (since_sw != '1)
                    since_sw++;
                if (cur_mode == MODE_COOL)
                begin
                    if (cool_count != '1)
                        cool_count++;
                    if (cool_count >= cool_len)
                        cur_mode = MODE_OFF;
                end
            end
            ACT_SAMPLE:
            begin
                if (active)
                begin
                    // Round half away from zero to whole degrees.
                    t   = temp;
                    mag = (t < 0) ? -t : t;
                    deg = (mag + 8) / 16;
                    if (t < 0)
                        deg = -deg;
                    want_heat = (deg < int'(tgt));
                    gap = int'(tgt) * 16 - t;
                    if (gap < 0)
                        gap = -gap;
                    if (want_heat != heater && since_sw > hold &&
                        (gap > int'(hyst) || first_pending))
                    begin
                        heater        = want_heat;
                        since_sw      = '0;
                        first_pending = 1'b0;
                        cur_mode      = want_heat ? MODE_HEAT : MODE_IDLE;
                    end
                end
            end
            ACT_ENABLE:
            begin
                if (!active)
                begin
                    since_sw      = '1;
                    first_pending = 1'b1;
                    cur_mode      = MODE_IDLE;
                end
            end
            default:
            begin
                if (active)
                begin
                    heater     = 1'b0;
                    cool_count = '0;
                    cur_mode   = MODE_COOL;
                end
            end
        endcase
        r.heat    = heater;
        r.op_mode = cur_mode;
        r.changed = (cur_mode != prior);
        return r;
    endfunction

    // Registers change only with the pipeline drained.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_TARGET: tgt = (val[6:0] > TARGET_MAX) ? TARGET_MAX : val[6:0];
            REG_HYST:   hyst = val[11:0];
            REG_HOLD:   hold = val;
            default:    cool_len = val;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Leaves in_valid high on return; the caller lowers it for a gap.
    task automatic offer_request(input logic [1:0] act, input logic [15:0] temp_bits,
                                 input bit typed, input thermo_result_t typed_want);
        thermo_result_t pred;
        in_valid    <= 1'b1;
        action      <= act;
        temperature <= temp_bits;
        do
            @(posedge clk);
        while (!in_ready);
        pred = thermostat_next(act, temp_bits);
        pending_results.push_back(typed ? typed_want : pred);
        sent_count++;
    endtask

    initial
    begin : receiver
        int cyc;
        int stall_style;
        cyc         = 0;
        stall_style = 0;
        out_ready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_go)
            begin
                out_ready  <= 1'b0;
                hold_off_go = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                if (cyc % 40 == 0)
                    stall_style = $urandom_range(0, 3);
                cyc++;
                case (stall_style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= $urandom_range(0, 1);
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (cyc % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        thermo_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result with no request pending: heat_drive %0b mode %0d",
                         $time, heat_drive, mode);
            end
            else
            begin
                want = pending_results.pop_front();
                if (heat_drive !== want.heat)
                begin
                    error_count++;
                    $display("%0t: heat_drive expected %0b actual %0b",
                             $time, want.heat, heat_drive);
                end
                if (mode !== want.op_mode)
                begin
                    error_count++;
                    $display("%0t: mode expected %0d actual %0d",
                             $time, want.op_mode, mode);
                end
                if (mode_changed !== want.changed)
                begin
                    error_count++;
                    $display("%0t: mode_changed expected %0b actual %0b",
                             $time, want.changed, mode_changed);
                end
                checked_count++;
                if (heat_drive !== last_heat)
                    switch_count++;
                last_heat = heat_drive;
                if (mode_changed)
                    change_count++;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int          phase;
        int          n;
        int          burst_left;
        int          gap;
        int          span;
        int          roll;
        int          near;
        logic [1:0]  act;
        logic [15:0] tbits;
        logic [15:0] tv;
        logic [15:0] hv;
        logic [15:0] dv;
        logic [15:0] cv;
        plan_row_t   row;

        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = REG_TARGET;
        cfg_data      = '0;
        in_valid      = 1'b0;
        action        = ACT_TICK;
        temperature   = '0;
        hold_off_go   = 1'b0;
        error_count   = 0;
        sent_count    = 0;
        checked_count = 0;
        switch_count  = 0;
        change_count  = 0;
        last_heat     = 1'b0;

        cur_mode      = MODE_OFF;
        heater        = 1'b0;
        since_sw      = '1;
        first_pending = 1'b1;
        cool_count    = '0;
        tgt           = TARGET_RESET;
        hyst          = HYST_RESET;
        hold          = HOLD_RESET;
        cool_len      = COOL_RESET;

        // Reset defaults: target 0, hysteresis 32, hold 30, cooldown 60.
        plan.push_back({ROW_TYPED, ACT_TICK,    16'h0000, 1'b0, MODE_OFF,  1'b0});
        plan.push_back({ROW_TYPED, ACT_SAMPLE,  16'h8000, 1'b0, MODE_OFF,  1'b0});
        plan.push_back({ROW_TYPED, ACT_DISABLE, 16'h0000, 1'b0, MODE_OFF,  1'b0});
        plan.push_back({ROW_TYPED, ACT_ENABLE,  16'h0000, 1'b0, MODE_IDLE, 1'b1});
        plan.push_back({ROW_TYPED, ACT_ENABLE,  16'hFFFF, 1'b0, MODE_IDLE, 1'b0});
        plan.push_back({ROW_TYPED, ACT_SAMPLE,  16'h7FFF, 1'b0, MODE_IDLE, 1'b0});
        plan.push_back({ROW_TYPED, ACT_SAMPLE,  16'h8000, 1'b1, MODE_HEAT, 1'b1});
        plan.push_back({ROW_TYPED, ACT_SAMPLE,  16'h7FFF, 1'b1, MODE_HEAT, 1'b0});
        plan.push_back({ROW_TYPED, ACT_DISABLE, 16'h0000, 1'b0, MODE_COOL, 1'b1});
        plan.push_back({ROW_TYPED, ACT_DISABLE, 16'h0000, 1'b0, MODE_COOL, 1'b0});
        plan.push_back({ROW_TYPED, ACT_ENABLE,  16'h0000, 1'b0, MODE_IDLE, 1'b1});
        // Target clamps to 100; no hysteresis, no hold, no cooldown.
        plan.push_back({ROW_CFG,   REG_TARGET,  16'hFFFF, 4'h0});
        plan.push_back({ROW_CFG,   REG_HYST,    16'h0000, 4'h0});
        plan.push_back({ROW_CFG,   REG_HOLD,    16'h0000, 4'h0});
        plan.push_back({ROW_CFG,   REG_COOL,    16'h0000, 4'h0});
        // 99.5 degrees rounds up to the target, 99.44 rounds down below it.
        plan.push_back({ROW_ITEM,  ACT_SAMPLE,  16'h0638, 4'h0});
        plan.push_back({ROW_ITEM,  ACT_SAMPLE,  16'h0637, 4'h0});
        plan.push_back({ROW_ITEM,  ACT_TICK,    16'h0000, 4'h0});
        plan.push_back({ROW_ITEM,  ACT_SAMPLE,  16'h0640, 4'h0});
        plan.push_back({ROW_ITEM,  ACT_SAMPLE,  16'h0641, 4'h0});
        plan.push_back({ROW_ITEM,  ACT_SAMPLE,  16'hFFF8, 4'h0});
        plan.push_back({ROW_ITEM,  ACT_DISABLE, 16'h0000, 4'h0});
        plan.push_back({ROW_ITEM,  ACT_TICK,    16'h0000, 4'h0});
        // Hold at all ones blocks every switch; one below lets the first go.
        plan.push_back({ROW_CFG,   REG_TARGET,  16'h00C8, 4'h0});
        plan.push_back({ROW_CFG,   REG_HYST,    16'hFFFF, 4'h0});
        plan.push_back({ROW_CFG,   REG_HOLD,    16'hFFFF, 4'h0});
        plan.push_back({ROW_CFG,   REG_COOL,    16'hFFFF, 4'h0});
        plan.push_back({ROW_ITEM,  ACT_ENABLE,  16'h0000, 4'h0});
        plan.push_back({ROW_ITEM,  ACT_SAMPLE,  16'h8000, 4'h0});
        plan.push_back({ROW_CFG,   REG_HOLD,    16'hFFFE, 4'h0});
        plan.push_back({ROW_ITEM,  ACT_SAMPLE,  16'h0477, 4'h0});
        plan.push_back({ROW_ITEM,  ACT_TICK,    16'h0000, 4'h0});
        plan.push_back({ROW_ITEM,  ACT_DISABLE, 16'h0000, 4'h0});
        plan.push_back({ROW_ITEM,  ACT_ENABLE,  16'h0000, 4'h0});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_CFG)
                write_reg(row.sel, row.value);
            else
                offer_request(row.sel, row.value, row.kind == ROW_TYPED, row.want);
        end

        burst_left = 0;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            roll = $urandom_range(0, 5);
            tv = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF : 16'($urandom);
            roll = $urandom_range(0, 5);
            hv = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF
                                                      : 16'($urandom_range(0, 48));
            roll = $urandom_range(0, 7);
            dv = (roll == 0) ? 16'hFFFF : (roll == 1) ? 16'hFFFE : (roll == 2) ? 16'h0000
                                                      : 16'($urandom_range(0, 4));
            roll = $urandom_range(0, 7);
            cv = (roll == 0) ? 16'hFFFF : (roll == 1) ? 16'h0000
                                                      : 16'($urandom_range(1, 6));
            write_reg(REG_TARGET, tv);
            write_reg(REG_HYST, hv);
            write_reg(REG_HOLD, dv);
            write_reg(REG_COOL, cv);
            if (phase == 3)
                hold_off_go = 1'b1;

            for (n = 0; n < PHASE_REQUESTS; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap > 0)
                    begin
                        in_valid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                burst_left--;

                // Steer toward enable, samples and ticks, then disable and cooldown.
                roll = $urandom_range(0, 99);
                if (cur_mode == MODE_OFF)
                    act = (roll < 60) ? ACT_ENABLE : (roll < 80) ? ACT_TICK
                                    : (roll < 90) ? ACT_SAMPLE : ACT_DISABLE;
                else if (cur_mode == MODE_COOL)
                    act = (roll < 60) ? ACT_TICK : (roll < 80) ? ACT_ENABLE
                                    : (roll < 90) ? ACT_SAMPLE : ACT_DISABLE;
                else
                    act = (roll < 55) ? ACT_SAMPLE : (roll < 90) ? ACT_TICK
                                    : (roll < 95) ? ACT_DISABLE : ACT_ENABLE;

                roll = $urandom_range(0, 99);
                if (roll < 70)
                begin
                    span  = int'(hyst) + 40;
                    near  = int'(tgt) * 16 + int'($urandom_range(0, 2 * span)) - span;
                    tbits = near[15:0];
                end
                else if (roll < 85)
                    tbits = 16'($urandom);
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       tbits = 16'h8000;
                        1:       tbits = 16'h7FFF;
                        2:       tbits = 16'h0000;
                        default: tbits = 16'hFFFF;
                    endcase
                end
                offer_request(act, tbits, 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d requests in a directed table and %0d random phases.",
                 sent_count, RANDOM_PHASES);
        $display("Checked %0d results: %0d heater switches, %0d mode changes.",
                 checked_count, switch_count, change_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== heater_thermostat_lockout.f =====
rtl/htl_pkg.sv
rtl/heater_thermostat_lockout.sv
dv/heater_thermostat_lockout_tb.sv
